// ===== sv/tlpc_pkg.sv =====
// Shared types and constants of the tile layer pixel compositor.
// No dependencies; every module file imports this package.
package tlpc_pkg;

  // four background lanes plus one sprite lane
  localparam int NumLayers = 4;
  localparam int NumLanes  = 5;
  localparam int SpriteLane = 4;

  localparam int ColorW  = 15;
  localparam int PixelW  = 16;
  localparam int PrioW   = 2;
  localparam int KeyW    = 5;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  // bit positions inside one six-bit window enable group
  localparam int WinSpriteBit = 4;
  localparam int WinEffectBit = 5;

  typedef logic [2:0] lane_id_t;
  typedef logic [5:0] win_en_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDispCtrl = 3'd0,
    CfgWin0H    = 3'd1,
    CfgWin0V    = 3'd2,
    CfgWin1H    = 3'd3,
    CfgWin1V    = 3'd4,
    CfgWinSet   = 3'd5,
    CfgBlend    = 3'd6,
    CfgLayerPri = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ModeTiled0 = 3'd0,
    ModeTiled1 = 3'd1,
    ModeTiled2 = 3'd2
  } mode_e;

  typedef enum logic [1:0] {
    EffNone     = 2'd0,
    EffAlpha    = 2'd1,
    EffBrighten = 2'd2,
    EffDarken   = 2'd3
  } effect_e;

  // one lane's candidate: lower key wins
  typedef struct packed {
    logic              hit;
    logic [KeyW-1:0]   key;
    logic [ColorW-1:0] color;
  } lane_cand_t;

  typedef struct packed {
    logic              top_valid;
    logic [ColorW-1:0] top_color;
    logic              lower_valid;
    logic [ColorW-1:0] lower_color;
    logic [1:0]        effect;
  } comp_res_t;

endpackage

// ===== sv/tlpc_if.sv =====
// Request channels of the tile layer pixel compositor: pixel input and result output.
// No dependencies.
interface tlpc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] layer0_pixel;
  logic [15:0] layer1_pixel;
  logic [15:0] layer2_pixel;
  logic [15:0] layer3_pixel;
  logic [15:0] sprite_pixel;
  logic [1:0]  sprite_priority;
  logic [1:0]  sprite_flags;

  modport source (
    output valid, pos_x, pos_y, layer0_pixel, layer1_pixel, layer2_pixel, layer3_pixel,
    output sprite_pixel, sprite_priority, sprite_flags,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, layer0_pixel, layer1_pixel, layer2_pixel, layer3_pixel,
    input  sprite_pixel, sprite_priority, sprite_flags,
    output ready
  );
endinterface

interface tlpc_out_if;
  logic        valid;
  logic        ready;
  logic        top_valid;
  logic [14:0] top_color;
  logic        lower_valid;
  logic [14:0] lower_color;
  logic [1:0]  effect;

  modport source (
    output valid, top_valid, top_color, lower_valid, lower_color, effect,
    input  ready
  );
  modport sink (
    input  valid, top_valid, top_color, lower_valid, lower_color, effect,
    output ready
  );
endinterface

// ===== sv/tlpc_window.sv =====
// Active window resolution: edge compares for win0 and win1, then priority select.
// Depends on tlpc_pkg.
module tlpc_window (
  input  logic [7:0]           pos_x_i,
  input  logic [7:0]           pos_y_i,
  input  logic                 spr_win_i,
  input  logic [15:0]          disp_ctrl_i,
  input  logic [15:0]          win0_h_i,
  input  logic [15:0]          win0_v_i,
  input  logic [15:0]          win1_h_i,
  input  logic [15:0]          win1_v_i,
  input  logic [31:0]          win_set_i,
  output tlpc_pkg::win_en_t    win_en_o
);
  import tlpc_pkg::*;

  // inside test with wrap when the start edge lies past the end edge
  function automatic logic in_span(logic [15:0] edges, logic [7:0] p);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = edges[15:8];
    hi = edges[7:0];
    if (lo <= hi) begin
      return (p >= lo) && (p < hi);
    end
    return (p >= lo) || (p < hi);
  endfunction

  logic w0_on, w1_on, ws_on;
  logic in_w0, in_w1;

  assign w0_on = disp_ctrl_i[13];
  assign w1_on = disp_ctrl_i[14];
  assign ws_on = disp_ctrl_i[15];
  assign in_w0 = w0_on && in_span(win0_h_i, pos_x_i) && in_span(win0_v_i, pos_y_i);
  assign in_w1 = w1_on && in_span(win1_h_i, pos_x_i) && in_span(win1_v_i, pos_y_i);

  // win0 over win1 over sprite window over outside; all enabled when no window is on
  always_comb begin
    if (in_w0) begin
      win_en_o = win_set_i[5:0];
    end else if (in_w1) begin
      win_en_o = win_set_i[13:8];
    end else if (ws_on && spr_win_i) begin
      win_en_o = win_set_i[29:24];
    end else if (w0_on || w1_on || ws_on) begin
      win_en_o = win_set_i[21:16];
    end else begin
      win_en_o = '1;
    end
  end

endmodule

// ===== sv/tlpc_lane.sv =====
// One compositing lane: decides whether its pixel takes part and builds its order key.
// Depends on tlpc_pkg.
module tlpc_lane (
  input  tlpc_pkg::lane_id_t              lane_id_i,
  input  logic                            enable_i,
  input  logic [tlpc_pkg::PixelW-1:0]     pixel_i,
  input  logic [tlpc_pkg::PrioW-1:0]      prio_i,
  output tlpc_pkg::lane_cand_t            cand_o
);
  import tlpc_pkg::*;

  logic [2:0] sub;

  // sprite goes ahead of backgrounds of equal priority, then layer number
  assign sub = (lane_id_i == lane_id_t'(SpriteLane)) ? 3'd0 : lane_id_i + 3'd1;

  assign cand_o.hit   = enable_i && pixel_i[PixelW-1];
  assign cand_o.key   = {prio_i, sub};
  assign cand_o.color = pixel_i[ColorW-1:0];

endmodule

// ===== sv/tlpc_merge.sv =====
// Merge stage: ranks the lane candidates, picks top and lower pixel, resolves the effect.
// Depends on tlpc_pkg.
module tlpc_merge (
  input  tlpc_pkg::lane_cand_t cand_i [tlpc_pkg::NumLanes],
  input  tlpc_pkg::win_en_t    win_en_i,
  input  logic [13:0]          blend_i,
  input  logic                 semi_i,
  output tlpc_pkg::comp_res_t  res_o
);
  import tlpc_pkg::*;

  logic [NumLanes-1:0] is_top;
  logic [NumLanes-1:0] is_low;
  logic [2:0]          rank [NumLanes];
  logic [ColorW-1:0]   top_col, low_col;
  logic                force_alpha, apply, low_ok;
  logic [1:0]          eff_mode;

  // rank of each candidate = number of present candidates with a smaller key
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NumLanes; j++) begin
        if (j != i && cand_i[j].hit && (cand_i[j].key < cand_i[i].key)) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
      is_top[i] = cand_i[i].hit && (rank[i] == 3'd0);
      is_low[i] = cand_i[i].hit && (rank[i] == 3'd1);
    end
  end

  // one-hot color select
  always_comb begin
    top_col = '0;
    low_col = '0;
    for (int i = 0; i < NumLanes; i++) begin
      top_col = top_col | ({ColorW{is_top[i]}} & cand_i[i].color);
      low_col = low_col | ({ColorW{is_low[i]}} & cand_i[i].color);
    end
  end

  // effect resolution
  assign eff_mode    = blend_i[7:6];
  assign force_alpha = is_top[SpriteLane] && semi_i;
  assign apply       = |(is_top & blend_i[4:0]) && win_en_i[WinEffectBit];
  assign low_ok      = (|is_low) && (force_alpha || eff_mode == EffAlpha)
                       && |(is_low & blend_i[12:8]);

  always_comb begin
    res_o.top_valid   = |is_top;
    res_o.top_color   = top_col;
    res_o.lower_valid = low_ok;
    res_o.lower_color = low_ok ? low_col : '0;
    if (force_alpha) begin
      res_o.effect = EffAlpha;
    end else if (apply) begin
      res_o.effect = eff_mode;
    end else begin
      res_o.effect = EffNone;
    end
  end

endmodule

// ===== sv/tile_layer_pixel_compositor_core.sv =====
// Top level of the tile layer pixel compositor: configuration registers, two-stage pipeline.
// Depends on tlpc_pkg, tlpc_if, tlpc_window, tlpc_lane and tlpc_merge.
//
// Usage: one request on in_i carries a screen position, four background pixels and a
// sprite pixel with its priority and flags. One result per request leaves on out_o with
// the top pixel, the lower blend target and the effect code.
// Stage one resolves the active window from the edge registers; stage two runs five lanes
// (four backgrounds, one sprite) side by side and the merge stage ranks them and picks the
// two front pixels. The result register is the output.
// A request passes the stage one register, then the result register, which drives out_o.
// Throughput: one request per clock while out_o.ready is high; the two pipeline
// registers each take a new request in the cycle their current content moves on.
// Stalls: when out_o.ready is low the result holds, the stage behind it holds, and
// in_i.ready falls once both are full; nothing is dropped.
// Reset (rst_ni low, asynchronous) empties the pipeline and zeroes the config registers.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the clock edge,
// truncated to the register width; write only while the pipeline is empty.
module tile_layer_pixel_compositor_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tlpc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  tlpc_in_if.sink                        in_i,
  tlpc_out_if.source                     out_o
);
  import tlpc_pkg::*;

  // configuration registers
  logic [15:0] disp_ctrl_q, win0_h_q, win0_v_q, win1_h_q, win1_v_q;
  logic [31:0] win_set_q;
  logic [13:0] blend_q;
  logic [7:0]  layer_pri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_ctrl_q <= '0;
      win0_h_q    <= '0;
      win0_v_q    <= '0;
      win1_h_q    <= '0;
      win1_v_q    <= '0;
      win_set_q   <= '0;
      blend_q     <= '0;
      layer_pri_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgDispCtrl: disp_ctrl_q <= cfg_wdata_i[15:0];
        CfgWin0H:    win0_h_q    <= cfg_wdata_i[15:0];
        CfgWin0V:    win0_v_q    <= cfg_wdata_i[15:0];
        CfgWin1H:    win1_h_q    <= cfg_wdata_i[15:0];
        CfgWin1V:    win1_v_q    <= cfg_wdata_i[15:0];
        CfgWinSet:   win_set_q   <= cfg_wdata_i;
        CfgBlend:    blend_q     <= cfg_wdata_i[13:0];
        CfgLayerPri: layer_pri_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_q, out_valid_q;
  logic s1_ready, s2_ready;

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  // stage one: window select
  win_en_t win_en;

  tlpc_window u_window (
    .pos_x_i    (in_i.pos_x),
    .pos_y_i    (in_i.pos_y),
    .spr_win_i  (in_i.sprite_flags[1]),
    .disp_ctrl_i(disp_ctrl_q),
    .win0_h_i   (win0_h_q),
    .win0_v_i   (win0_v_q),
    .win1_h_i   (win1_h_q),
    .win1_v_i   (win1_v_q),
    .win_set_i  (win_set_q),
    .win_en_o   (win_en)
  );

  win_en_t           s1_win_q;
  logic [PixelW-1:0] s1_pix_q [NumLanes];
  logic [PrioW-1:0]  s1_sprio_q;
  logic              s1_semi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_win_q    <= win_en;
      s1_pix_q[0] <= in_i.layer0_pixel;
      s1_pix_q[1] <= in_i.layer1_pixel;
      s1_pix_q[2] <= in_i.layer2_pixel;
      s1_pix_q[3] <= in_i.layer3_pixel;
      s1_pix_q[SpriteLane] <= in_i.sprite_pixel;
      s1_sprio_q  <= in_i.sprite_priority;
      s1_semi_q   <= in_i.sprite_flags[0];
    end
  end

  // stage two: layers allowed by the tiled mode, the layer enables and the window
  logic [NumLayers-1:0] mode_mask, allowed;

  always_comb begin
    case (disp_ctrl_q[2:0])
      ModeTiled0: mode_mask = 4'hF;
      ModeTiled1: mode_mask = 4'h7;
      ModeTiled2: mode_mask = 4'hC;
      default:    mode_mask = 4'h0;
    endcase
  end

  assign allowed = mode_mask & disp_ctrl_q[11:8] & s1_win_q[NumLayers-1:0];

  logic [NumLanes-1:0] lane_en;
  logic [PrioW-1:0]    lane_prio [NumLanes];
  lane_cand_t          cand [NumLanes];

  always_comb begin
    for (int l = 0; l < NumLayers; l++) begin
      lane_en[l]   = allowed[l];
      lane_prio[l] = layer_pri_q[2*l +: 2];
    end
    lane_en[SpriteLane]   = s1_win_q[WinSpriteBit];
    lane_prio[SpriteLane] = s1_sprio_q;
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    tlpc_lane u_lane (
      .lane_id_i(lane_id_t'(g)),
      .enable_i (lane_en[g]),
      .pixel_i  (s1_pix_q[g]),
      .prio_i   (lane_prio[g]),
      .cand_o   (cand[g])
    );
  end

  comp_res_t res, res_q;

  tlpc_merge u_merge (
    .cand_i  (cand),
    .win_en_i(s1_win_q),
    .blend_i (blend_q),
    .semi_i  (s1_semi_q),
    .res_o   (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.top_valid   = res_q.top_valid;
  assign out_o.top_color   = res_q.top_color;
  assign out_o.lower_valid = res_q.lower_valid;
  assign out_o.lower_color = res_q.lower_color;
  assign out_o.effect      = res_q.effect;

  // checks
  a_lower_needs_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!res_q.lower_valid || res_q.top_valid))
    else $error("lower pixel without a top pixel");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.top_valid) |->
      (res_q.top_color == '0 && res_q.effect == EffNone && res_q.lower_color == '0))
    else $error("empty result carries nonzero fields");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted request lost at stage one");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_win_q)))
    else $error("stage one changed while stalled");

endmodule
